@@ sv/dss2ts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss2ts_pkg
// Shared types and constants for the DSS to MPEG-2 transport stream converter.
// ----------------------------------------------------------------------------
package dss2ts_pkg;

    // DSS packet framing
    localparam int unsigned DSS_LEN   = 131;
    localparam int unsigned PAD_COUNT = 57;
    localparam int unsigned POS_W     = 8;
    localparam int unsigned IDX_W     = 6;

    localparam logic [7:0] DSS_SYNC  = 8'h1d;
    localparam logic [7:0] TS_SYNC   = 8'h47;
    localparam logic [7:0] PAD_BYTE  = 8'hff;
    localparam logic [12:0] NULL_PID = 13'h1fff;

    // Positions within a DSS packet that need special handling
    localparam logic [POS_W-1:0] POS_SYNC  = 8'd0;
    localparam logic [POS_W-1:0] POS_HDR1  = 8'd1;
    localparam logic [POS_W-1:0] POS_HDR2  = 8'd2;
    localparam logic [POS_W-1:0] POS_DROP  = 8'd3;
    localparam logic [POS_W-1:0] POS_FINAL = POS_W'(DSS_LEN - 1);

    // Continuity counter store
    localparam int unsigned SCID_W   = 12;
    localparam int unsigned CC_W     = 4;
    localparam int unsigned CC_DEPTH = 1 << SCID_W;

    // Last word index of each item kind
    localparam logic [IDX_W-1:0] IDX_SINGLE = 6'd0;
    localparam logic [IDX_W-1:0] IDX_HDR    = 6'd2;
    localparam logic [IDX_W-1:0] IDX_PAD    = IDX_W'(PAD_COUNT);

    // Scrambling code in DSS header byte one
    localparam logic [1:0] SCR_CLEAR = 2'd0;
    localparam logic [1:0] SCR_ODD   = 2'd1;

    // Kind of work held for the output side
    typedef enum logic [2:0] {
        ITEM_PLAIN = 3'b001,   // one word, the stored byte
        ITEM_HDR   = 3'b010,   // PID high, PID low, flags and counter
        ITEM_FINAL = 3'b100    // stored byte then padding
    } item_kind_t;

    typedef struct packed {
        item_kind_t         kind;
        logic [7:0]         data;
        logic [SCID_W-1:0]  scid;
        logic [1:0]         code;
        logic [IDX_W-1:0]   last_idx;
    } item_t;

    // Counter write-back request from the output side
    typedef struct packed {
        logic               en;
        logic [SCID_W-1:0]  addr;
        logic [CC_W-1:0]    value;
    } cc_upd_t;

endpackage

@@ sv/dss2ts_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss2ts_emit
// Holds one decoded item and expands it into output words through a
// registered output stage.
// ----------------------------------------------------------------------------
module dss2ts_emit
    import dss2ts_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  item_t           in_item,
    output logic            in_ready,
    input  logic [CC_W-1:0] cc_rdata,
    output cc_upd_t         cc_upd,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);

    logic             s1_valid_reg, s1_valid_next;
    item_t            s1_item_reg, s1_item_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_data_reg, out_data_next;
    logic             out_last_reg, out_last_next;

    logic             load;
    logic             at_last;
    logic             item_done;
    logic [12:0]      pid;
    logic [7:0]       hdr_byte;
    logic [7:0]       word;

    // Word selection for the held item
    always_comb
    begin
        load      = s1_valid_reg && (!out_valid_reg || m_tready);
        at_last   = (k_reg == s1_item_reg.last_idx);
        item_done = load && at_last;
        in_ready  = !s1_valid_reg || item_done;

        pid      = (s1_item_reg.scid == '0) ? NULL_PID : {1'b0, s1_item_reg.scid};
        hdr_byte = {s1_item_reg.code == SCR_ODD, s1_item_reg.code == SCR_CLEAR,
                    1'b0, 1'b1, cc_rdata};

        case (s1_item_reg.kind)
            ITEM_HDR:
            begin
                if (k_reg == IDX_SINGLE)
                    word = {3'b000, pid[12:8]};
                else if (k_reg == IDX_SINGLE + 1'b1)
                    word = pid[7:0];
                else
                    word = hdr_byte;
            end
            ITEM_FINAL:
                word = (k_reg == IDX_SINGLE) ? s1_item_reg.data : PAD_BYTE;
            default:
                word = s1_item_reg.data;
        endcase
    end

    // Item holding stage
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_item_next  = s1_item_reg;
        k_next        = k_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
            s1_item_next  = in_item;
            k_next        = '0;
        end
        else if (item_done)
            s1_valid_next = 1'b0;
        else if (load)
            k_next = k_reg + 1'b1;
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = word;
            out_last_next  = at_last;
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // Counter write-back when the flags word goes out
    always_comb
    begin
        cc_upd.en    = load && (s1_item_reg.kind == ITEM_HDR) && (k_reg == IDX_HDR);
        cc_upd.addr  = s1_item_reg.scid;
        cc_upd.value = cc_rdata + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg  <= s1_item_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ sv/dss_to_mpeg2_ts_converter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_to_mpeg2_ts_converter_top
// Converts 131-byte DSS packets into 188-byte MPEG-2 transport packets.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one DSS stream byte per word; s_tuser marks the first
//   byte of a buffer. A buffer whose first byte is not 0x1d passes through.
//   Master channel m_*: one transport stream byte per word; m_tlast is high
//   on the last word produced by a given input word.
//   An accepted input word is held in the holding stage; its output words
//   pass the output register. Header bytes one and three produce no output.
//   Throughput: one input word a cycle while each gives a single output word
//   and m_tready is high; the header word gives 3 output words and the final
//   packet byte 58, all bound by the single output register (one output word
//   a cycle). Header bytes one and three each leave a gap in the output
//   stream.
//   Reset: the 4096-entry continuity counter memory is cleared one entry per
//   cycle, so s_tready stays low after reset until every entry is cleared.
//   Stalls: with m_tready low one more item is held internally, after which
//   s_tready drops until the output drains.
// ----------------------------------------------------------------------------
module dss_to_mpeg2_ts_converter_top
    import dss2ts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tuser,   // [0] buffer_start
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // run_last
);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              pass_reg, pass_next;
    logic [7:0]        hdr1_reg, hdr1_next;
    logic [SCID_W:0]   clr_cnt_reg, clr_cnt_next;

    logic              clr_done;
    logic              emit_ready;
    logic              accept;
    logic              has_result;
    logic              pass_eff;
    logic [POS_W-1:0]  pos_eff;
    item_t             item;
    cc_upd_t           cc_upd;
    logic [CC_W-1:0]   cc_rdata_reg;
    logic [CC_W-1:0]   cc_mem [CC_DEPTH];

    assign clr_done = clr_cnt_reg[SCID_W];
    assign s_tready = clr_done && emit_ready;
    assign accept   = s_tvalid && s_tready;

    // Decode of the incoming word against packet position
    always_comb
    begin
        pass_eff = s_tuser ? (s_tdata != DSS_SYNC) : pass_reg;
        pos_eff  = s_tuser ? POS_SYNC : pos_reg;

        item.kind     = ITEM_PLAIN;
        item.data     = s_tdata;
        item.scid     = {hdr1_reg[SCID_W-9:0], s_tdata};
        item.code     = hdr1_reg[5:4];
        item.last_idx = IDX_SINGLE;
        has_result    = 1'b1;

        if (!pass_eff)
        begin
            case (pos_eff)
                POS_SYNC:
                    item.data = TS_SYNC;
                POS_HDR1, POS_DROP:
                    has_result = 1'b0;
                POS_HDR2:
                begin
                    item.kind     = ITEM_HDR;
                    item.last_idx = IDX_HDR;
                end
                POS_FINAL:
                begin
                    item.kind     = ITEM_FINAL;
                    item.last_idx = IDX_PAD;
                end
                default:
                    item.kind = ITEM_PLAIN;
            endcase
        end
    end

    // Packet position tracking
    always_comb
    begin
        pass_next = pass_reg;
        pos_next  = pos_reg;
        hdr1_next = hdr1_reg;
        if (accept)
        begin
            pass_next = pass_eff;
            if (pass_eff)
                pos_next = pos_eff;
            else
                pos_next = (pos_eff == POS_FINAL) ? POS_SYNC : pos_eff + 1'b1;
            if (!pass_eff && (pos_eff == POS_HDR1))
                hdr1_next = s_tdata;
        end
    end

    // Clearing sweep over the counter memory after reset
    assign clr_cnt_next = clr_done ? clr_cnt_reg : clr_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            pass_reg    <= 1'b0;
            hdr1_reg    <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            pass_reg    <= pass_next;
            hdr1_reg    <= hdr1_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Continuity counter memory: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (!clr_done)
            cc_mem[clr_cnt_reg[SCID_W-1:0]] <= '0;
        else if (cc_upd.en)
            cc_mem[cc_upd.addr] <= cc_upd.value;
        if (accept && (item.kind == ITEM_HDR) && has_result)
            cc_rdata_reg <= cc_mem[item.scid];
    end

    dss2ts_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid && clr_done && has_result),
        .in_item  (item),
        .in_ready (emit_ready),
        .cc_rdata (cc_rdata_reg),
        .cc_upd   (cc_upd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ sv/dss2ts_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss2ts_checker
// Port-level checks for the DSS to MPEG-2 transport stream converter.
// ----------------------------------------------------------------------------
module dss2ts_checker
    import dss2ts_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // A stalled output word stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word withdrawn while stalled");

    // A stalled output word keeps its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

    // Counter clear keeps the input closed straight after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !s_tready)
    else $error("input opened before counter clear");

    // A pass-through word taken under a stalled output fills the holding stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(s_tvalid && s_tready && s_tuser && (s_tdata != DSS_SYNC)
              && m_tvalid && !m_tready) && m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted with holding stage full");

endmodule

bind dss_to_mpeg2_ts_converter_top dss2ts_checker u_dss2ts_checker (.*);
